// File: design/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Every assertion is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge out of reset.
`define U8_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds at any rising edge out of reset.
`define U8_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: design/u8u16_pkg.sv
// Types and constants for the UTF-8 to UTF-16 decoder.
// Used by the decode stage, the result queue and the top level; depends on nothing.
package u8u16_pkg;

	// Code unit given for invalid and cut-off input.
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;

	// Payload masks of lead and following bytes.
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] TAIL_MASK  = 8'h3F;
	localparam logic [7:0] LEAD3_FLAG = 8'h20;

	// Number of bytes still owed to a held sequence.
	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_ONE  = 2'd1;
	localparam logic [1:0] NEED_TWO  = 2'd2;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// One result transaction.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_of_run;
		logic        text_done;
	} result_t;

	// Everything one input byte produces: zero, one or two results.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} dec_out_t;

endpackage

// File: design/u8u16_chan_if.sv
// Valid/ready channel interfaces for the decoder's byte input and code unit output.
// Self-contained; the payload widths are those of the byte stream and of UTF-16.
interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_text;

	modport source(output valid, output byte_in, output end_of_text, input ready);
	modport sink(input valid, input byte_in, input end_of_text, output ready);
endinterface

interface u8u16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_of_run;
	logic        text_done;

	modport source(output valid, output code_unit, output last_of_run, output text_done,
		input ready);
	modport sink(input valid, input code_unit, input last_of_run, input text_done,
		output ready);
endinterface

// File: design/u8u16_decode.sv
// Decode stage: holds the partial-sequence state and turns one byte into its results.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          byte_in,
	input  logic                end_of_text,
	output u8u16_pkg::dec_out_t dec
);

	logic [1:0]  need_q;
	logic [7:0]  lead_q;
	logic [7:0]  tail_q;
	logic [1:0]  need_d;
	logic [7:0]  lead_d;
	logic [7:0]  tail_d;
	logic [15:0] alone;
	logic [7:0]  lead_bits;
	logic [7:0]  mid_bits;
	logic [7:0]  low_bits;
	logic [15:0] joined;

	// A byte decoded on its own: ASCII passes, anything else is replaced.
	assign alone = byte_in[7] ? u8u16_pkg::REPLACEMENT : {8'h00, byte_in};

	// Combine the held lead, the held first tail and the current byte.
	assign mid_bits = tail_q & u8u16_pkg::TAIL_MASK;
	assign low_bits = byte_in & u8u16_pkg::TAIL_MASK;
	always_comb begin
		if ((lead_q & u8u16_pkg::LEAD3_FLAG) != 8'h00) begin
			lead_bits = lead_q & u8u16_pkg::LEAD3_MASK;
			joined    = {lead_bits[3:0], mid_bits[5:0], low_bits[5:0]};
		end else begin
			lead_bits = lead_q & u8u16_pkg::LEAD2_MASK;
			joined    = {5'b00000, lead_bits[4:0], low_bits[5:0]};
		end
	end

	// Results and next state for the byte in the stage.
	always_comb begin
		need_d     = u8u16_pkg::NEED_NONE;
		lead_d     = 8'h00;
		tail_d     = 8'h00;
		dec.count  = 2'd1;
		dec.first  = '{code_unit: alone, last_of_run: 1'b1, text_done: end_of_text};
		dec.second = '{code_unit: alone, last_of_run: 1'b1, text_done: 1'b1};
		case (need_q)
			u8u16_pkg::NEED_TWO: begin
				if (end_of_text) begin
					// Three-byte sequence cut off: replace the lead, then the byte alone.
					dec.count = 2'd2;
					dec.first = '{code_unit: u8u16_pkg::REPLACEMENT, last_of_run: 1'b0,
						text_done: 1'b0};
				end else begin
					need_d    = u8u16_pkg::NEED_ONE;
					lead_d    = lead_q;
					tail_d    = byte_in;
					dec.count = 2'd0;
				end
			end
			u8u16_pkg::NEED_ONE: begin
				dec.first.code_unit = joined;
			end
			default: begin
				// Nothing held: a two- or three-byte lead is held back unless the text ends here.
				if (!end_of_text && (byte_in inside {[8'hE0:8'hEF]})) begin
					need_d    = u8u16_pkg::NEED_TWO;
					lead_d    = byte_in;
					dec.count = 2'd0;
				end else if (!end_of_text && (byte_in inside {[8'hC0:8'hDF]})) begin
					need_d    = u8u16_pkg::NEED_ONE;
					lead_d    = byte_in;
					dec.count = 2'd0;
				end
			end
		endcase
	end

	// Sequence state, updated when the byte leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= u8u16_pkg::NEED_NONE;
			lead_q <= 8'h00;
			tail_q <= 8'h00;
		end else if (advance) begin
			need_q <= need_d;
			lead_q <= lead_d;
			tail_q <= tail_d;
		end
	end

	`U8_ASSERT_NEVER(a_need_unused, need_q == 2'd3, "unused sequence state reached")
	`U8_ASSERT(a_eot_clears, advance && end_of_text |=> need_q == u8u16_pkg::NEED_NONE,
		"state held after end of text")

endmodule

// File: design/u8u16_res_queue.sv
// Result queue: takes up to two results a cycle and hands out one per transaction.
// Depends on u8u16_pkg, u8u16_chan_if and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_res_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8u16_pkg::dec_out_t din,
	output logic                space_ok,
	u8u16_out_if.source         unit_ch
);

	u8u16_pkg::result_t                 mem_q [u8u16_pkg::QDEPTH];
	logic [u8u16_pkg::PTR_W-1:0]        wr_ptr_q;
	logic [u8u16_pkg::PTR_W-1:0]        rd_ptr_q;
	logic [u8u16_pkg::CNT_W-1:0]        count_q;
	logic [1:0]                         n_push;
	logic                               pop;

	// Room for the worst case of two results, judged on the registered fill level.
	assign space_ok = count_q <= u8u16_pkg::CNT_W'(u8u16_pkg::QDEPTH - 2);
	assign n_push   = push ? din.count : 2'd0;
	assign pop      = unit_ch.valid && unit_ch.ready;

	// The head entry drives the output directly from registers.
	assign unit_ch.valid       = count_q != '0;
	assign unit_ch.code_unit   = mem_q[rd_ptr_q].code_unit;
	assign unit_ch.last_of_run = mem_q[rd_ptr_q].last_of_run;
	assign unit_ch.text_done   = mem_q[rd_ptr_q].text_done;

	// Storage for queued results.
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= din.first;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + u8u16_pkg::PTR_W'(1)] <= din.second;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + u8u16_pkg::PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + u8u16_pkg::PTR_W'(pop);
			count_q  <= count_q + u8u16_pkg::CNT_W'(n_push) - u8u16_pkg::CNT_W'(pop);
		end
	end

	`U8_ASSERT(a_no_overflow, count_q <= u8u16_pkg::CNT_W'(u8u16_pkg::QDEPTH),
		"result queue fill level out of range")
	`U8_ASSERT_NEVER(a_push_full, (n_push != 2'd0) && !space_ok,
		"results pushed without room in the queue")

endmodule

// File: design/utf8_to_utf16_decoder_core.sv
// UTF-8 to UTF-16 decoder for the Basic Multilingual Plane, one byte per transaction.
// Each byte is held in the input register and decoded, and its results are written into
// the queue, whose head entry drives the output from registers.
// Throughput: one byte per cycle while the queue has room; a byte producing two results is absorbed by the queue.
// Input stalls only when the four-entry result queue is backed up by the output side.
// Reset (arst_n low, asynchronous) empties the stage and queue and clears held sequences.
module utf8_to_utf16_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	u8u16_in_if.sink    byte_ch,
	u8u16_out_if.source unit_ch
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eot_s1;
	logic                advance;
	logic                space_ok;
	u8u16_pkg::dec_out_t dec;

	// The stage empties into the queue when there is room.
	assign advance       = valid_s1 && space_ok;
	assign byte_ch.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.byte_in;
			eot_s1  <= byte_ch.end_of_text;
		end
	end

	u8u16_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.byte_in     (byte_s1),
		.end_of_text (eot_s1),
		.dec         (dec)
	);

	u8u16_res_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.din      (dec),
		.space_ok (space_ok),
		.unit_ch  (unit_ch)
	);

endmodule
